// File: rtl/mh64_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh64_pkg
// Shared constants, types and helpers for the 64-bit murmur2 hash block.
// ----------------------------------------------------------------------------
package mh64_pkg;

   localparam int          LENGTH_BITS = 32;
   localparam logic [63:0] MUR_M       = 64'hc6a4a7935bd1e995;
   localparam int          MUR_R       = 47;
   localparam logic [3:0]  FULL_WORD   = 4'd8;

   typedef logic [LENGTH_BITS-1:0] len_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_LEN,
      ST_KEY1,
      ST_KEY2,
      ST_MIX,
      ST_TAIL,
      ST_FINAL,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      MUL_LO_LO,
      MUL_LO_HI,
      MUL_HI_LO,
      MUL_SUM
   } mul_step_type;

   typedef struct packed {
      logic        start;
      logic [63:0] operand;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] product;
   } mul_rsp_type;

   // v ^ (v >> r), the murmur shift-xor
   function automatic logic [63:0] xorshift(input logic [63:0] v);
      return v ^ (v >> MUR_R);
   endfunction

endpackage

// File: rtl/murmur2_hash64_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur2_hash64_top
// MurmurHash64A over a stream of 64-bit little-endian key words.
// ----------------------------------------------------------------------------
// Each shared-unit multiply: four steps (three 32x32 products, then a sum).
// Multiplies per beat, n = 0 to 5:
//   +1 if first, +3 for a full word, +1 for a 1..7 byte tail on the last beat, +1 if last.
// The final hash waits in fin_ff for a free output slot, then is registered.
// Synchronous active-high reset clears seed, hash state, error and output valid.
// ----------------------------------------------------------------------------
module murmur2_hash64_top (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data,
   // key word beats
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_key_word,
   input  logic [3:0]  req_byte_count,
   input  logic        req_first_word,
   input  logic        req_last_word,
   input  logic [31:0] req_key_length,
   // hash result beats
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_hash_value,
   output logic        rsp_length_error
);

   mh64_pkg::state_type   state_ff, state_in;

   // key state
   logic [63:0]           seed_ff,  seed_in;
   logic [63:0]           hash_ff,  hash_in;
   mh64_pkg::len_type     bytes_ff, bytes_in;
   mh64_pkg::len_type     expect_ff, expect_in;
   logic                  err_ff,   err_in;

   // latched beat
   logic [63:0]           word_ff,  word_in;
   logic [3:0]            cnt_ff,   cnt_in;
   logic                  first_ff, first_in;
   logic                  last_ff,  last_in;

   // finished hash and output register
   logic [63:0]           fin_ff,   fin_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [63:0]           rsp_hash_ff,  rsp_hash_in;
   logic                  rsp_err_ff,   rsp_err_in;

   mh64_pkg::mul_req_type mul_req;
   mh64_pkg::mul_rsp_type mul_rsp;

   logic                  req_accept;
   logic                  slot_free;
   logic [3:0]            cnt_clamp;
   logic                  cnt_over;
   logic [63:0]           tail_mask;

   // dispatch: which multiply a beat needs first, given the running hash
   logic [63:0]           disp_hash;
   mh64_pkg::state_type   disp_state;
   logic [63:0]           disp_op;

   mh64_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != mh64_pkg::ST_IDLE);
   // output slot takes a new result when empty or being drained this cycle
   assign slot_free  = !rsp_valid_ff || !rsp_stall;

   // oversized counts act as a full word and flag the key
   assign cnt_over  = (req_byte_count > mh64_pkg::FULL_WORD);
   assign cnt_clamp = cnt_over ? mh64_pkg::FULL_WORD : req_byte_count;

   // low cnt bytes of the tail word; only used for counts 1..7
   assign tail_mask = ~(~64'd0 << {cnt_ff[2:0], 3'b000});

   // running hash seen by dispatch: fresh seed mix right after the length multiply
   always_comb begin
      if (state_ff == mh64_pkg::ST_LEN) begin
         disp_hash = seed_ff ^ mul_rsp.product;
      end else begin
         disp_hash = hash_ff;
      end
   end

   always_comb begin
      if (cnt_ff == mh64_pkg::FULL_WORD) begin
         disp_state = mh64_pkg::ST_KEY1;
         disp_op    = word_ff;
      end else if (last_ff && (cnt_ff != 4'd0)) begin
         disp_state = mh64_pkg::ST_TAIL;
         disp_op    = disp_hash ^ (word_ff & tail_mask);
      end else if (last_ff) begin
         disp_state = mh64_pkg::ST_FINAL;
         disp_op    = mh64_pkg::xorshift(disp_hash);
      end else begin
         // short word that is not last: counted and flagged, hash untouched
         disp_state = mh64_pkg::ST_IDLE;
         disp_op    = 64'd0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mh64_pkg::ST_IDLE: begin
            if (req_accept) state_in = mh64_pkg::ST_LOAD;
         end
         mh64_pkg::ST_LOAD: begin
            state_in = first_ff ? mh64_pkg::ST_LEN : disp_state;
         end
         mh64_pkg::ST_LEN: begin
            if (mul_rsp.done) state_in = disp_state;
         end
         mh64_pkg::ST_KEY1: begin
            if (mul_rsp.done) state_in = mh64_pkg::ST_KEY2;
         end
         mh64_pkg::ST_KEY2: begin
            if (mul_rsp.done) state_in = mh64_pkg::ST_MIX;
         end
         mh64_pkg::ST_MIX: begin
            if (mul_rsp.done) state_in = last_ff ? mh64_pkg::ST_FINAL : mh64_pkg::ST_IDLE;
         end
         mh64_pkg::ST_TAIL: begin
            if (mul_rsp.done) state_in = mh64_pkg::ST_FINAL;
         end
         mh64_pkg::ST_FINAL: begin
            if (mul_rsp.done) state_in = mh64_pkg::ST_OUT;
         end
         mh64_pkg::ST_OUT: begin
            if (slot_free) state_in = mh64_pkg::ST_IDLE;
         end
         default: begin
            state_in = mh64_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs: multiplier requests and datapath updates
   always_comb begin
      mul_req     = '0;
      seed_in     = csr_wr_en ? csr_wr_data : seed_ff;
      hash_in     = hash_ff;
      bytes_in    = bytes_ff;
      expect_in   = expect_ff;
      err_in      = err_ff;
      word_in     = word_ff;
      cnt_in      = cnt_ff;
      first_in    = first_ff;
      last_in     = last_ff;
      fin_in      = fin_ff;
      rsp_hash_in = rsp_hash_ff;
      rsp_err_in  = rsp_err_ff;
      // drop the result once taken
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         mh64_pkg::ST_IDLE: begin
            if (req_accept) begin
               // capture the beat; a first word restarts the byte count and error
               word_in  = req_key_word;
               cnt_in   = cnt_clamp;
               first_in = req_first_word;
               last_in  = req_last_word;
               if (req_first_word) begin
                  expect_in = mh64_pkg::len_type'(req_key_length);
                  bytes_in  = mh64_pkg::len_type'(cnt_clamp);
                  err_in    = 1'b0;
               end else begin
                  bytes_in  = bytes_ff + mh64_pkg::len_type'(cnt_clamp);
               end
               if (cnt_over || ((cnt_clamp != mh64_pkg::FULL_WORD) && !req_last_word)) begin
                  err_in = 1'b1;
               end
            end
         end
         mh64_pkg::ST_LOAD: begin
            if (first_ff) begin
               mul_req.start   = 1'b1;
               mul_req.operand = 64'(expect_ff);
            end else begin
               mul_req.start   = (disp_state != mh64_pkg::ST_IDLE);
               mul_req.operand = disp_op;
            end
         end
         mh64_pkg::ST_LEN: begin
            if (mul_rsp.done) begin
               hash_in         = disp_hash;
               mul_req.start   = (disp_state != mh64_pkg::ST_IDLE);
               mul_req.operand = disp_op;
            end
         end
         mh64_pkg::ST_KEY1: begin
            if (mul_rsp.done) begin
               mul_req.start   = 1'b1;
               mul_req.operand = mh64_pkg::xorshift(mul_rsp.product);
            end
         end
         mh64_pkg::ST_KEY2: begin
            if (mul_rsp.done) begin
               mul_req.start   = 1'b1;
               mul_req.operand = hash_ff ^ mul_rsp.product;
            end
         end
         mh64_pkg::ST_MIX: begin
            if (mul_rsp.done) begin
               hash_in         = mul_rsp.product;
               mul_req.start   = last_ff;
               mul_req.operand = mh64_pkg::xorshift(mul_rsp.product);
            end
         end
         mh64_pkg::ST_TAIL: begin
            if (mul_rsp.done) begin
               hash_in         = mul_rsp.product;
               mul_req.start   = 1'b1;
               mul_req.operand = mh64_pkg::xorshift(mul_rsp.product);
            end
         end
         mh64_pkg::ST_FINAL: begin
            // avalanche works on a copy; the running hash stays as mixed
            if (mul_rsp.done) fin_in = mh64_pkg::xorshift(mul_rsp.product);
         end
         mh64_pkg::ST_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = fin_ff;
               rsp_err_in   = err_ff || (bytes_ff != expect_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mh64_pkg::ST_IDLE;
         seed_ff      <= 64'd0;
         hash_ff      <= 64'd0;
         bytes_ff     <= '0;
         expect_ff    <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         hash_ff      <= hash_in;
         bytes_ff     <= bytes_in;
         expect_ff    <= expect_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      cnt_ff      <= cnt_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      fin_ff      <= fin_in;
      rsp_hash_ff <= rsp_hash_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hash_value   = rsp_hash_ff;
   assign rsp_length_error = rsp_err_ff;

endmodule

// File: rtl/mh64_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh64_mul
// Shared multiplier: low 64 bits of operand * M from three 32x32 products.
// ----------------------------------------------------------------------------
module mh64_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  mh64_pkg::mul_req_type mul_req,
   output mh64_pkg::mul_rsp_type mul_rsp
);

   logic                   busy_ff,  busy_in;
   logic                   done_ff,  done_in;
   mh64_pkg::mul_step_type step_ff,  step_in;
   logic [63:0]            a_ff,     a_in;
   logic [63:0]            prod_ff,  prod_in;
   logic [63:0]            acc_ff,   acc_in;
   logic [31:0]            mul_x;
   logic [31:0]            mul_y;

   // pick operand halves for the single 32x32 multiplier
   always_comb begin
      mul_x = (step_ff == mh64_pkg::MUL_HI_LO) ? a_ff[63:32] : a_ff[31:0];
      mul_y = (step_ff == mh64_pkg::MUL_LO_HI) ? mh64_pkg::MUR_M[63:32]
                                               : mh64_pkg::MUR_M[31:0];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      a_in    = a_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      if (!busy_ff) begin
         if (mul_req.start) begin
            busy_in = 1'b1;
            step_in = mh64_pkg::MUL_LO_LO;
            a_in    = mul_req.operand;
         end
      end else begin
         prod_in = 64'(mul_x) * 64'(mul_y);
         case (step_ff)
            mh64_pkg::MUL_LO_LO: begin
               step_in = mh64_pkg::MUL_LO_HI;
            end
            mh64_pkg::MUL_LO_HI: begin
               acc_in  = prod_ff;
               step_in = mh64_pkg::MUL_HI_LO;
            end
            mh64_pkg::MUL_HI_LO: begin
               acc_in  = acc_ff + {prod_ff[31:0], 32'd0};
               step_in = mh64_pkg::MUL_SUM;
            end
            mh64_pkg::MUL_SUM: begin
               acc_in  = acc_ff + {prod_ff[31:0], 32'd0};
               busy_in = 1'b0;
               done_in = 1'b1;
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= mh64_pkg::MUL_LO_LO;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = acc_ff;

endmodule

// File: rtl/mh64_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh64_checker
// Port-level checks on the murmur2 hash block, bound to the top level.
// ----------------------------------------------------------------------------
module mh64_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_hash_value,
   input logic        rsp_length_error
);

   // block is busy right after it takes a beat
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after accepted beat");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_hash_value)
                                    && $stable(rsp_length_error)))
      else $error("stalled result changed");

   // reset leaves the block ready and the output empty
   assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("bad state after reset");

   // the block only goes busy on an accepted beat
   assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid && !req_stall))
      else $error("input stalled without an accepted beat");

   // a result is produced only while a beat is being worked on
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while idle");

endmodule

bind murmur2_hash64_top mh64_checker u_mh64_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_hash_value   (rsp_hash_value),
   .rsp_length_error (rsp_length_error)
);
